// ===== hw/rtl/ism_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ism_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_MRG_RD0,
    S_MRG_LD0,
    S_MRG_RD,
    S_MRG_CMP,
    S_OUT
  } ism_state_t;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PAIR_W = 2 * VAL_W;

endpackage
`default_nettype wire

// ===== hw/rtl/ism_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ism_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/interval_sort_merge.sv =====
// Collects closed signed intervals, one start/end pair per transfer, until a
// transfer marked last, then sends the merged intervals in ascending order
// with last_of_run on the final one and overflowed set if pairs were dropped
// for lack of room. Each pair is insertion-sorted into a single-port-pair RAM
// as it arrives: each stored pair that sorts above it is read, compared and
// moved up one place (one RAM read and one compare per step) until the new
// pair's place is found; a dropped pair is not stored. After the last pair
// the merge pass reads the stored pairs in order and folds each into the
// running interval or sends it out; each result transfer may stall.
// in_ready is high only between sets or between pairs, so a new pair is
// taken only after the previous one has been handled.
`timescale 1ns / 1ps
`default_nettype none
module interval_sort_merge #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_interval_start,
  input  wire logic [31:0] in_interval_end,
  input  wire logic        in_last_interval,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_merged_start,
  output logic [31:0]      out_merged_end,
  output logic             out_last_of_run,
  output logic             out_overflowed
);

  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned VW = ism_pkg::VAL_W;
  localparam int unsigned PW = ism_pkg::PAIR_W;

  ism_pkg::ism_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  logic [CW-1:0] j_r;
  logic [CW-1:0] i_r;
  logic [VW-1:0] cur_s_r, cur_e_r;
  logic          last_r;
  logic [VW-1:0] run_s_r, run_e_r;
  logic          out_valid_r;
  logic [VW-1:0] out_s_r, out_e_r;
  logic          out_last_r, out_ovf_r;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0] ram_wdata, ram_rdata;
  logic [VW-1:0] rd_s, rd_e;

  logic          in_xfer, out_xfer;
  logic          room;
  logic          more;

  // shared compare unit
  logic [VW-1:0] cmp_a0, cmp_b0, cmp_a1, cmp_b1;
  logic          lt0, eq0, lt1;
  logic          ins_lt, mrg_sep;

  assign rd_s = ram_rdata[PW-1:VW];
  assign rd_e = ram_rdata[VW-1:0];

  assign in_ready  = (state_r == ism_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_xfer  = out_valid_r && out_ready;
  assign room      = (cnt_r < CW'(MAX_INTERVALS));
  assign more      = (i_r < cnt_r);

  assign out_merged_start = out_s_r;
  assign out_merged_end   = out_e_r;
  assign out_last_of_run  = out_last_r;
  assign out_overflowed   = out_ovf_r;

  // operand select for the compare unit
  always_comb begin
    if (state_r == ism_pkg::S_INS_CMP) begin
      cmp_a0 = cur_s_r;
      cmp_b0 = rd_s;
      cmp_a1 = cur_e_r;
      cmp_b1 = rd_e;
    end else begin
      cmp_a0 = run_e_r;
      cmp_b0 = rd_s;
      cmp_a1 = run_e_r;
      cmp_b1 = rd_e;
    end
  end

  assign lt0     = ($signed(cmp_a0) < $signed(cmp_b0));
  assign eq0     = (cmp_a0 == cmp_b0);
  assign lt1     = ($signed(cmp_a1) < $signed(cmp_b1));
  assign ins_lt  = lt0 || (eq0 && lt1);
  assign mrg_sep = lt0;

  ism_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_INTERVALS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ism_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (room) begin
            state_nxt = ism_pkg::S_INS_RD;
          end else if (in_last_interval) begin
            state_nxt = ism_pkg::S_MRG_RD0;
          end
        end
      end
      ism_pkg::S_INS_RD: begin
        if (j_r == '0) begin
          state_nxt = last_r ? ism_pkg::S_MRG_RD0 : ism_pkg::S_IDLE;
        end else begin
          state_nxt = ism_pkg::S_INS_CMP;
        end
      end
      ism_pkg::S_INS_CMP: begin
        if (ins_lt) begin
          state_nxt = ism_pkg::S_INS_RD;
        end else begin
          state_nxt = last_r ? ism_pkg::S_MRG_RD0 : ism_pkg::S_IDLE;
        end
      end
      ism_pkg::S_MRG_RD0: state_nxt = ism_pkg::S_MRG_LD0;
      ism_pkg::S_MRG_LD0: state_nxt = ism_pkg::S_MRG_RD;
      ism_pkg::S_MRG_RD: begin
        state_nxt = more ? ism_pkg::S_MRG_CMP : ism_pkg::S_OUT;
      end
      ism_pkg::S_MRG_CMP: begin
        state_nxt = mrg_sep ? ism_pkg::S_OUT : ism_pkg::S_MRG_RD;
      end
      ism_pkg::S_OUT: begin
        if (out_xfer) begin
          state_nxt = out_last_r ? ism_pkg::S_IDLE : ism_pkg::S_MRG_RD;
        end
      end
      default: state_nxt = ism_pkg::S_IDLE;
    endcase
  end

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j_r[AW-1:0];
    ram_wdata = {cur_s_r, cur_e_r};
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      ism_pkg::S_INS_RD: begin
        if (j_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_r[AW-1:0] - AW'(1);
        end
      end
      ism_pkg::S_INS_CMP: begin
        ram_we = 1'b1;
        if (ins_lt) begin
          ram_wdata = ram_rdata;
        end
      end
      ism_pkg::S_MRG_RD0: ram_re = 1'b1;
      ism_pkg::S_MRG_RD: begin
        ram_re    = more;
        ram_raddr = i_r[AW-1:0];
      end
      default: ram_re = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ism_pkg::S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        if (room) begin
          cnt_r <= cnt_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (state_r == ism_pkg::S_MRG_RD && !more) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
      end else if (state_r == ism_pkg::S_MRG_CMP && mrg_sep) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ism_pkg::S_IDLE: begin
        cur_s_r <= in_interval_start;
        cur_e_r <= in_interval_end;
        last_r  <= in_last_interval;
        j_r     <= cnt_r;
      end
      ism_pkg::S_INS_CMP: begin
        if (ins_lt) begin
          j_r <= j_r - CW'(1);
        end
      end
      ism_pkg::S_MRG_LD0: begin
        run_s_r <= rd_s;
        run_e_r <= rd_e;
        i_r     <= CW'(1);
      end
      ism_pkg::S_MRG_RD: begin
        if (!more) begin
          out_s_r    <= run_s_r;
          out_e_r    <= run_e_r;
          out_last_r <= 1'b1;
          out_ovf_r  <= ovf_r;
        end
      end
      ism_pkg::S_MRG_CMP: begin
        i_r <= i_r + CW'(1);
        if (mrg_sep) begin
          out_s_r    <= run_s_r;
          out_e_r    <= run_e_r;
          out_last_r <= 1'b0;
          out_ovf_r  <= ovf_r;
          run_s_r    <= rd_s;
          run_e_r    <= rd_e;
        end else if (lt1) begin
          run_e_r <= rd_e;
        end
      end
      default: begin
        i_r <= i_r;
      end
    endcase
  end

  // checks
  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_INTERVALS))
    else $error("fill count beyond capacity");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_of_run) |=> (cnt_r == '0 && !ovf_r && in_ready))
    else $error("set state not cleared after final transfer");

endmodule
`default_nettype wire

// ===== tb/tb_interval_sort_merge.sv =====
`timescale 1ns / 1ps
module tb_interval_sort_merge;

  localparam int unsigned CAP = 64;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        last;
  } span_t;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        last;
    logic        ovf;
  } merged_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_interval_start = '0;
  logic [31:0] in_interval_end = '0;
  logic in_last_interval = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_merged_start;
  logic [31:0] out_merged_end;
  logic out_last_of_run;
  logic out_overflowed;

  interval_sort_merge #(.MAX_INTERVALS(CAP)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_interval_start(in_interval_start), .in_interval_end(in_interval_end),
    .in_last_interval(in_last_interval),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_merged_start(out_merged_start), .out_merged_end(out_merged_end),
    .out_last_of_run(out_last_of_run), .out_overflowed(out_overflowed)
  );

  always #1 clk = ~clk;

  span_t   pending_spans[$];
  merged_t expected_merges[$];
  int      errors = 0;
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0;
  bit      in_taken = 1'b0;

  // predictor state
  logic [31:0] set_lo[CAP];
  logic [31:0] set_hi[CAP];
  int          set_count = 0;
  bit          set_ovf = 1'b0;

  function automatic bit pair_lt(logic [31:0] al, logic [31:0] ah,
                                 logic [31:0] bl, logic [31:0] bh);
    if (al != bl) return $signed(al) < $signed(bl);
    return $signed(ah) < $signed(bh);
  endfunction

  // absorb one accepted pair; on last, sort, merge and queue merged spans
  task automatic absorb_span(span_t sp);
    logic [31:0] cl, ch, run_lo, run_hi;
    int j;
    merged_t m;
    if (set_count < CAP) begin
      set_lo[set_count] = sp.lo;
      set_hi[set_count] = sp.hi;
      set_count++;
    end else begin
      set_ovf = 1'b1;
    end
    if (!sp.last) return;
    for (int i = 1; i < set_count; i++) begin
      cl = set_lo[i];
      ch = set_hi[i];
      j = i;
      while (j > 0 && pair_lt(cl, ch, set_lo[j-1], set_hi[j-1])) begin
        set_lo[j] = set_lo[j-1];
        set_hi[j] = set_hi[j-1];
        j--;
      end
      set_lo[j] = cl;
      set_hi[j] = ch;
    end
    run_lo = set_lo[0];
    run_hi = set_hi[0];
    for (int i = 1; i <= set_count; i++) begin
      if (i < set_count && !($signed(run_hi) < $signed(set_lo[i]))) begin
        if ($signed(run_hi) < $signed(set_hi[i])) run_hi = set_hi[i];
      end else begin
        m.lo = run_lo;
        m.hi = run_hi;
        m.last = (i == set_count);
        m.ovf = set_ovf;
        expected_merges.insert(expected_merges.size(), m);
        if (i < set_count) begin
          run_lo = set_lo[i];
          run_hi = set_hi[i];
        end
      end
    end
    set_count = 0;
    set_ovf = 1'b0;
  endtask

  function automatic logic [31:0] rand_point(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 200) - 100;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic add_set(int n, int mode);
    span_t sp;
    logic [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_point(mode);
      b = ($urandom_range(0, 9) == 0) ? rand_point(mode)
                                       : a + $urandom_range(0, 12);
      if (mode == 0) b = $urandom;
      sp.lo = a;
      sp.hi = b;
      sp.last = (i == n - 1);
      pending_spans.insert(pending_spans.size(), sp);
    end
  endtask

  task automatic add_pair(logic [31:0] a, logic [31:0] b, logic l);
    span_t sp;
    sp.lo = a;
    sp.hi = b;
    sp.last = l;
    pending_spans.insert(pending_spans.size(), sp);
  endtask

  // stimulus
  initial begin
    int total;
    add_pair(32'd5, 32'd7, 1'b1);
    add_pair(32'd1, 32'd3, 1'b0);
    add_pair(32'd3, 32'd5, 1'b0);
    add_pair(32'd10, 32'd12, 1'b0);
    add_pair(32'd8, 32'd9, 1'b1);
    add_pair(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_pair(32'hffff_ffff, 32'h0000_0000, 1'b1);
    add_pair(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    add_pair(32'd20, 32'd10, 1'b0);
    add_pair(32'd20, 32'd5, 1'b0);
    add_pair(32'd12, 32'd15, 1'b1);
    total = pending_spans.size();
    // two overflowing sets, the last marked item dropped in each
    add_set(CAP + 3, 1);
    add_set(CAP + 1, 0);
    total += 2 * CAP + 4;
    while (total < 410) begin
      int n, mode;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      mode = $urandom_range(0, 2);
      add_set(n, mode);
      total += n;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // input transfer seen at the last rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold the payload
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_spans.size() > 0) begin
        span_t sp;
        sp = pending_spans.pop_front();
        in_valid <= 1'b1;
        in_interval_start <= sp.lo;
        in_interval_end <= sp.hi;
        in_last_interval <= sp.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_off) out_ready <= 1'b0;
    else if (stall_phase[7:6] == 2'b11) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // long hold-off once early in the run
  initial begin
    @(posedge rst_n);
    repeat (60) @(negedge clk);
    hold_off = 1'b1;
    repeat (600) @(negedge clk);
    hold_off = 1'b0;
  end

  // monitor: predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        span_t sp;
        sp.lo = in_interval_start;
        sp.hi = in_interval_end;
        sp.last = in_last_interval;
        absorb_span(sp);
      end
      if (out_valid && out_ready) begin
        if (expected_merges.size() == 0) begin
          $error("unexpected result transfer start=%0d end=%0d",
                 $signed(out_merged_start), $signed(out_merged_end));
          errors++;
        end else begin
          merged_t m;
          m = expected_merges.pop_front();
          if (out_merged_start !== m.lo) begin
            $error("merged_start expected %0d got %0d", $signed(m.lo),
                   $signed(out_merged_start));
            errors++;
          end
          if (out_merged_end !== m.hi) begin
            $error("merged_end expected %0d got %0d", $signed(m.hi),
                   $signed(out_merged_end));
            errors++;
          end
          if (out_last_of_run !== m.last) begin
            $error("last_of_run expected %0b got %0b", m.last, out_last_of_run);
            errors++;
          end
          if (out_overflowed !== m.ovf) begin
            $error("overflowed expected %0b got %0b", m.ovf, out_overflowed);
            errors++;
          end
        end
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_n);
    wait (stim_done && !in_valid);
    wait (expected_merges.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_merges.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
